### sv/i2c_adc_pkg.sv
// Package: shared types, op codes and tables for the I2C ADC register interface.
`default_nettype none
package i2c_adc_pkg;
  localparam int unsigned DefTicksPerUs = 1;

  typedef enum logic [2:0] {
    OP_START_WR = 3'd0,
    OP_START_RD = 3'd1,
    OP_WR_BYTE  = 3'd2,
    OP_RD_BYTE  = 3'd3,
    OP_TICK     = 3'd4
  } op_e;

  localparam logic [1:0] PH_FIRST   = 2'd0;
  localparam logic [1:0] PH_SECOND  = 2'd1;
  localparam logic [1:0] PH_POINTER = 2'd2;

  localparam logic [7:0] PTR_CONV = 8'd0;
  localparam logic [7:0] PTR_CFG  = 8'd1;
  localparam logic [7:0] PTR_LO   = 8'd2;
  localparam logic [7:0] PTR_HI   = 8'd3;

  // one queued bus word
  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         data_byte;
    logic signed [23:0] ain_a;
    logic signed [23:0] ain_b;
    logic signed [23:0] ain_c;
    logic signed [23:0] ain_d;
  } item_t;

  function automatic logic [12:0] rate_us(input logic [2:0] sel);
    case (sel)
      3'd0: rate_us = 13'd7812;
      3'd1: rate_us = 13'd4000;
      3'd2: rate_us = 13'd2040;
      3'd3: rate_us = 13'd1086;
      3'd4: rate_us = 13'd625;
      3'd5: rate_us = 13'd416;
      default: rate_us = 13'd303;
    endcase
  endfunction

  function automatic logic [22:0] full_scale_uv(input logic [2:0] sel);
    case (sel)
      3'd0: full_scale_uv = 23'd6144000;
      3'd1: full_scale_uv = 23'd4096000;
      3'd2: full_scale_uv = 23'd2048000;
      3'd3: full_scale_uv = 23'd1024000;
      3'd4: full_scale_uv = 23'd512000;
      default: full_scale_uv = 23'd256000;
    endcase
  endfunction
endpackage
`default_nettype wire

### sv/i2c_adc_fifo.sv
// Short queue between the front (accept) and back (execute) parts.
`default_nettype none
module i2c_adc_fifo
  import i2c_adc_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  item_t push_data_i,
  output logic  full_o,
  input  wire   pop_i,
  output item_t pop_data_o,
  output logic  empty_o
);
  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign pop_data_o = mem_q[rd_q];
  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
endmodule
`default_nettype wire

### sv/i2c_adc_div.sv
// Serial unsigned divider: quotient of a 36-bit dividend by a 24-bit divisor.
`default_nettype none
module i2c_adc_div (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [35:0] num_i,
  input  wire  [23:0] den_i,
  output logic        done_o,
  output logic [35:0] quo_o
);
  logic [35:0] quo_q;
  logic [24:0] rem_q;
  logic [23:0] den_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [24:0] sh;
  logic        ge;

  assign sh = {rem_q[23:0], quo_q[35]};
  assign ge = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1; cnt_q <= 6'd35;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0; done_o <= 1'b1;
        end
      end
    end
  end

  // one quotient bit a cycle, restoring form
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i; rem_q <= '0; den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? sh - {1'b0, den_q} : sh;
      quo_q <= {quo_q[34:0], ge};
    end
  end

  assign quo_o = quo_q;
endmodule
`default_nettype wire

### sv/i2c_adc_core.sv
// Back part: register file, conversion timer and result scaling.
`default_nettype none
module i2c_adc_core
  import i2c_adc_pkg::*;
#(
  parameter int unsigned TicksPerUs = DefTicksPerUs,
  localparam int unsigned TickW = $clog2(7812 * TicksPerUs + 1)
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  item_t      item_i,
  input  wire        empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [7:0] read_data_o,
  output logic       busy_o,
  output logic       done_o
);
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e      state_q;
  logic [1:0]  phase_q;
  logic [7:0]  ptr_q;
  logic [15:0] asm_q, conv_q, cfg_q, lo_q, hi_q;
  logic [TickW-1:0] ticks_q;
  logic        conv_q_busy;
  logic        neg_q;
  logic        div_start, div_done;
  logic [35:0] quo;
  logic [35:0] num_q;
  logic [23:0] den_q;

  logic signed [24:0] v;
  logic [24:0] mag;
  logic [23:0] fs2;
  logic [22:0] fs;
  logic [11:0] sat_code;
  logic        sat_hit;
  logic [11:0] q12;
  logic [11:0] code;
  logic [TickW-1:0] tick_dec;
  logic [7:0]  rd_byte;

  assign fs  = full_scale_uv(cfg_q[11:9]);
  assign fs2 = {fs, 1'b0};

  always_comb begin
    case (cfg_q[14:12])
      3'd0: v = 25'(item_i.ain_a) - 25'(item_i.ain_b);
      3'd1: v = 25'(item_i.ain_a) - 25'(item_i.ain_d);
      3'd2: v = 25'(item_i.ain_b) - 25'(item_i.ain_d);
      3'd3: v = 25'(item_i.ain_c) - 25'(item_i.ain_d);
      3'd4: v = 25'(item_i.ain_a);
      3'd5: v = 25'(item_i.ain_b);
      3'd6: v = 25'(item_i.ain_c);
      default: v = 25'(item_i.ain_d);
    endcase
  end
  assign mag = v[24] ? 25'(-v) : 25'(v);
  assign sat_hit  = (v >= $signed({2'b00, fs})) || (v < -$signed({2'b00, fs}));
  assign sat_code = v[24] ? 12'h800 : 12'h7ff;

  // byte returned by a read word
  always_comb begin
    rd_byte = '0;
    if (item_i.op == OP_RD_BYTE) begin
      case (phase_q)
        PH_FIRST: begin
          case (ptr_q)
            PTR_CONV: rd_byte = conv_q[15:8];
            PTR_CFG:  rd_byte = cfg_q[15:8];
            PTR_LO:   rd_byte = lo_q[15:8];
            PTR_HI:   rd_byte = hi_q[15:8];
            default:  rd_byte = asm_q[15:8];
          endcase
        end
        PH_SECOND: rd_byte = asm_q[7:0];
        default: ;
      endcase
    end
  end

  // launch the divide while num_q and den_q still hold the completing tick
  assign div_start = state_q == ST_WAIT;

  i2c_adc_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_q), .den_i(den_q),
    .done_o(div_done), .quo_o(quo)
  );

  // only a positive code of +2048 clamps; -2048 stays in range
  assign q12  = (!neg_q && (quo > 36'd2047)) ? 12'd2047 : quo[11:0];
  assign code = neg_q ? 12'(-q12) : q12;
  assign tick_dec = (ticks_q != '0) ? ticks_q - TickW'(1) : ticks_q;

  assign pop_o = (state_q == ST_IDLE) && !empty_i;
  assign out_valid_o = state_q == ST_OUT;
  assign busy_o = conv_q_busy;

  always_ff @(posedge clk_i) begin
    num_q <= 36'(mag) * 36'd4097;
    den_q <= fs2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; phase_q <= PH_FIRST; ptr_q <= '0; asm_q <= '0;
      conv_q <= '0; cfg_q <= '0; lo_q <= '0; hi_q <= '0; ticks_q <= '0;
      conv_q_busy <= 1'b0; neg_q <= 1'b0; read_data_o <= '0; done_o <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: if (!empty_i) begin
          read_data_o <= rd_byte;
          done_o <= (item_i.op == OP_TICK) && conv_q_busy && (tick_dec == '0);
          state_q <= ST_OUT;
          case (item_i.op)
            OP_START_WR: phase_q <= PH_POINTER;
            OP_START_RD: phase_q <= PH_FIRST;
            OP_WR_BYTE: begin
              case (phase_q)
                PH_POINTER: begin ptr_q <= item_i.data_byte; phase_q <= PH_FIRST; end
                PH_FIRST: begin asm_q <= {item_i.data_byte, 8'h00}; phase_q <= PH_SECOND; end
                PH_SECOND: begin
                  asm_q <= {asm_q[15:8], item_i.data_byte};
                  phase_q <= PH_FIRST;
                  case (ptr_q)
                    PTR_CFG: begin
                      cfg_q <= {1'b0, asm_q[14:8], item_i.data_byte};
                      if (asm_q[15]) begin
                        ticks_q <= TickW'(rate_us(item_i.data_byte[7:5]) * TicksPerUs);
                        conv_q_busy <= 1'b1;
                      end
                    end
                    PTR_LO: lo_q <= {asm_q[15:8], item_i.data_byte};
                    PTR_HI: hi_q <= {asm_q[15:8], item_i.data_byte};
                    default: ;
                  endcase
                end
                default: ;
              endcase
            end
            OP_RD_BYTE: begin
              case (phase_q)
                PH_FIRST: begin
                  phase_q <= PH_SECOND;
                  case (ptr_q)
                    PTR_CONV: asm_q <= conv_q;
                    PTR_CFG:  asm_q <= cfg_q;
                    PTR_LO:   asm_q <= lo_q;
                    PTR_HI:   asm_q <= hi_q;
                    default: ;
                  endcase
                end
                PH_SECOND: phase_q <= PH_FIRST;
                default: ;
              endcase
            end
            OP_TICK: if (conv_q_busy) begin
              ticks_q <= tick_dec;
              if (tick_dec == '0) begin
                conv_q_busy <= 1'b0;
                cfg_q[15] <= 1'b1;
                if (sat_hit) conv_q <= {sat_code, 4'h0};
                else begin
                  neg_q <= v[24]; state_q <= ST_WAIT;
                end
              end
            end
            default: ;
          endcase
        end
        ST_WAIT: state_q <= ST_DIV;
        ST_DIV: if (div_done) begin
          conv_q <= {code, 4'h0}; state_q <= ST_OUT;
        end
        ST_OUT: if (out_ready_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### sv/i2c_adc_register_interface.sv
// Top level of the I2C ADC register interface: queue plus register/convert core.
// Usage:
//  Slave channel s_axis_*: one bus word per transfer (start write, start read,
//  write byte, read byte, or a microsecond tick with the four analog inputs).
//  Master channel m_axis_*: exactly one result word per input word, in order:
//  read byte, busy flag and done flag.
//  Words enter a two-entry queue; the core then executes them one at a time.
//  A result word is registered in the core once it takes its input word from the
//  queue; a tick that ends an unsaturated conversion first passes the wait and
//  divide states for the serial divide (one quotient bit per cycle, 36 bits)
//  that scales the sample to full scale.
//  The core takes no new word until the result word of the last one has left.
//  A stalled master holds the result word; the queue keeps accepting until
//  full, then s_axis_tready drops.
//  Reset (rst_ni low, asynchronous) clears all registers, the pointer and
//  timer; no clearing pass is needed.
`default_nettype none
module i2c_adc_register_interface
  import i2c_adc_pkg::*;
#(
  parameter int unsigned TicksPerUs = DefTicksPerUs
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: op[2:0], data_byte[10:3], ain_a[34:11], ain_b[58:35],
  //        ain_c[82:59], ain_d[106:83], zero fill [111:107]
  input  wire [111:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata: read_data[7:0], conversion_busy[8], conversion_done[9], zero [15:10]
  output logic [15:0] m_axis_tdata
);
  item_t in_item, q_item;
  logic  full, empty, pop;
  logic  [7:0] rd;
  logic  busy, done;

  assign in_item = '{op: s_axis_tdata[2:0], data_byte: s_axis_tdata[10:3],
                     ain_a: s_axis_tdata[34:11], ain_b: s_axis_tdata[58:35],
                     ain_c: s_axis_tdata[82:59], ain_d: s_axis_tdata[106:83]};
  assign s_axis_tready = !full;

  // hold words here while the core works
  i2c_adc_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(s_axis_tvalid && !full), .push_data_i(in_item),
    .full_o(full), .pop_i(pop), .pop_data_o(q_item), .empty_o(empty)
  );

  i2c_adc_core #(.TicksPerUs(TicksPerUs)) u_core (
    .clk_i, .rst_ni, .item_i(q_item), .empty_i(empty), .pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .read_data_o(rd), .busy_o(busy), .done_o(done)
  );

  assign m_axis_tdata = {6'd0, done, busy, rd};
endmodule
`default_nettype wire
